### design/wpf_pkg.sv
// Shared widths, codes and types for the waypoint path follower.
package wpf_pkg;

  // field and datapath widths
  localparam int COORD_W = 32;
  localparam int DIFF_W  = 33;   // difference of two coordinates
  localparam int DIR_W   = 18;   // signed Q1.16 direction
  localparam int DIRM_W  = 17;   // direction magnitude
  localparam int STEP_W  = 38;   // step = ms * speed / 1000
  localparam int MS_W    = 16;
  localparam int SPD_W   = 31;

  // serial multiplier: a times b, one bit of b per cycle
  localparam int MUL_AW = 38;
  localparam int MUL_BW = 33;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  // serial divider: one quotient bit per cycle
  localparam int DIV_NW = 49;
  localparam int DIV_DW = 34;

  // serial square root: one root bit per cycle
  localparam int SQ_RW = 68;
  localparam int SQ_QW = SQ_RW / 2;
  localparam int SQ_MW = SQ_QW + 3;

  localparam logic [DIV_DW-1:0] MS_PER_S = DIV_DW'(1000);

  // mode codes
  localparam logic [1:0] MODE_START  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;   // unused, position echoed

  // one queued waypoint
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } wp_t;

endpackage

### design/waypoint_path_follower.sv
// Waypoint path follower: top level with sequencer, waypoint queue and result register.
//
// One item is worked on at a time; in_ready is high only while the sequencer is idle,
// and the next item is taken while a finished result still waits in the output
// register. All arithmetic runs through three shared bit-serial units: a multiplier,
// a divider and a square root. An append or an unused mode goes straight to the
// result; a path start runs two squares, a root and, for a nonzero length, two divides;
// a tick that advances runs a step multiply and divide, three squares, a root and two
// multiplies; a tick that snaps and pops the next waypoint also re-aims, and one that
// snaps with the queue empty stops.
module waypoint_path_follower #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_pos_x,
  input  logic [31:0] in_pos_y,
  input  logic [31:0] in_pos_z,
  input  logic [31:0] in_wp_x,
  input  logic [31:0] in_wp_y,
  input  logic [31:0] in_wp_z,
  input  logic [15:0] in_elapsed_ms,
  input  logic [30:0] in_speed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_new_x,
  output logic [31:0] out_new_y,
  output logic [31:0] out_new_z,
  output logic        out_stopped,
  output logic        out_overflow
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [15:0] {
    ST_IDLE  = 16'h0001,
    ST_A_GO  = 16'h0002,
    ST_A_MX  = 16'h0004,
    ST_A_MZ  = 16'h0008,
    ST_A_SQ  = 16'h0010,
    ST_A_DX  = 16'h0020,
    ST_A_DZ  = 16'h0040,
    ST_T_MUL = 16'h0080,
    ST_T_DIV = 16'h0100,
    ST_T_SX  = 16'h0200,
    ST_T_SY  = 16'h0400,
    ST_T_SZ  = 16'h0800,
    ST_T_SQ  = 16'h1000,
    ST_T_AX  = 16'h2000,
    ST_T_AZ  = 16'h4000,
    ST_DONE  = 16'h8000
  } state_t;

  state_t state_r;

  // path state
  wpf_pkg::wp_t                     tgt_r;
  logic [wpf_pkg::DIR_W-1:0]        dir_x_r;
  logic [wpf_pkg::DIR_W-1:0]        dir_z_r;
  logic [IDX_W-1:0]                 head_r;
  logic [CNT_W-1:0]                 count_r;
  wpf_pkg::wp_t                     mem [QUEUE_DEPTH];
  wpf_pkg::wp_t                     rd_r;

  // working registers; nx/ny/nz double as the position being aimed from
  logic [31:0]                      nx_r, ny_r, nz_r;
  logic                             stop_r, ovf_r;
  logic [wpf_pkg::SQ_RW-1:0]        sum_r;
  logic [wpf_pkg::SQ_QW-1:0]        len_r;
  logic [wpf_pkg::STEP_W-1:0]       step_r;

  // result register
  logic                             out_valid_r;
  logic [31:0]                      out_x_r, out_y_r, out_z_r;
  logic                             out_stop_r, out_ovf_r;

  // unit launch registers
  logic                             mul_go_r, div_go_r, sq_go_r;
  logic [wpf_pkg::MUL_AW-1:0]       mul_a_r;
  logic [wpf_pkg::MUL_BW-1:0]       mul_b_r;
  logic [wpf_pkg::DIV_NW-1:0]       div_n_r;
  logic [wpf_pkg::DIV_DW-1:0]       div_d_r;
  logic [wpf_pkg::SQ_RW-1:0]        sq_rad_r;
  logic                             mul_done, div_done, sq_done;
  logic [wpf_pkg::MUL_PW-1:0]       mul_p;
  logic [wpf_pkg::DIV_NW-1:0]       div_q;
  logic [wpf_pkg::SQ_QW-1:0]        sq_root;

  logic                             in_fire, out_fire, q_full, res_load;
  logic [CNT_W:0]                   slot_sum;
  logic [IDX_W-1:0]                 slot, head_inc;
  logic [wpf_pkg::DIFF_W-1:0]       dx, dy, dz, dx_m, dy_m, dz_m;
  logic [wpf_pkg::DIR_W-1:0]        dxm_full, dzm_full;
  logic [wpf_pkg::SQ_RW-1:0]        sum_add;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign q_full   = (count_r == CNT_W'(QUEUE_DEPTH));
  // finished result moves into the output register
  assign res_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // queue slot arithmetic, wrapping at the depth
  assign slot_sum = (CNT_W + 1)'(head_r) + (CNT_W + 1)'(count_r);
  assign slot     = (slot_sum >= (CNT_W + 1)'(QUEUE_DEPTH))
                    ? IDX_W'(slot_sum - (CNT_W + 1)'(QUEUE_DEPTH)) : IDX_W'(slot_sum);
  assign head_inc = (head_r == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;

  // differences from the working position to the target, and magnitudes
  assign dx   = {tgt_r.x[31], tgt_r.x} - {nx_r[31], nx_r};
  assign dy   = {tgt_r.y[31], tgt_r.y} - {ny_r[31], ny_r};
  assign dz   = {tgt_r.z[31], tgt_r.z} - {nz_r[31], nz_r};
  assign dx_m = dx[wpf_pkg::DIFF_W-1] ? ~dx + 1'b1 : dx;
  assign dy_m = dy[wpf_pkg::DIFF_W-1] ? ~dy + 1'b1 : dy;
  assign dz_m = dz[wpf_pkg::DIFF_W-1] ? ~dz + 1'b1 : dz;
  assign dxm_full = dir_x_r[wpf_pkg::DIR_W-1] ? ~dir_x_r + 1'b1 : dir_x_r;
  assign dzm_full = dir_z_r[wpf_pkg::DIR_W-1] ? ~dir_z_r + 1'b1 : dir_z_r;
  assign sum_add  = sum_r + wpf_pkg::SQ_RW'(mul_p);

  // signed direction from a quotient magnitude
  function automatic logic [wpf_pkg::DIR_W-1:0] signed_dir(
    input logic [wpf_pkg::DIV_NW-1:0] q, input logic neg);
    logic [wpf_pkg::DIR_W-1:0] m;
    m = {1'b0, q[wpf_pkg::DIRM_W-1:0]};
    return neg ? ~m + 1'b1 : m;
  endfunction

  // position plus or minus (product >> 16), saturated to 32 bits
  function automatic logic [31:0] sat_move(
    input logic [31:0] p, input logic [wpf_pkg::MUL_PW-1:0] prod, input logic neg);
    logic [40:0] pe, me, r;
    pe = {{9{p[31]}}, p};
    me = {2'b00, prod[54:16]};
    r  = neg ? pe - me : pe + me;
    if (!r[40] && (|r[39:31]))      return 32'h7fff_ffff;
    else if (r[40] && !(&r[39:31])) return 32'h8000_0000;
    else                            return r[31:0];
  endfunction

  // queue storage
  always_ff @(posedge clk) begin
    if (in_fire && (in_mode == wpf_pkg::MODE_APPEND) && !q_full) begin
      mem[slot] <= '{x: in_wp_x, y: in_wp_y, z: in_wp_z};
    end
    rd_r <= mem[head_r];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tgt_r       <= '0;
      dir_x_r     <= '0;
      dir_z_r     <= '0;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      mul_go_r    <= 1'b0;
      div_go_r    <= 1'b0;
      sq_go_r     <= 1'b0;
    end else begin
      mul_go_r <= 1'b0;
      div_go_r <= 1'b0;
      sq_go_r  <= 1'b0;
      if (res_load)      out_valid_r <= 1'b1;
      else if (out_fire) out_valid_r <= 1'b0;

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            nx_r   <= in_pos_x;
            ny_r   <= in_pos_y;
            nz_r   <= in_pos_z;
            stop_r <= 1'b0;
            ovf_r  <= 1'b0;
            case (in_mode)
              wpf_pkg::MODE_START: begin
                head_r  <= '0;
                count_r <= '0;
                tgt_r   <= '{x: in_wp_x, y: in_wp_y, z: in_wp_z};
                state_r <= ST_A_GO;
              end
              wpf_pkg::MODE_APPEND: begin
                if (q_full) ovf_r <= 1'b1;
                else        count_r <= count_r + 1'b1;
                state_r <= ST_DONE;
              end
              wpf_pkg::MODE_TICK: begin
                mul_a_r  <= wpf_pkg::MUL_AW'(in_speed);
                mul_b_r  <= wpf_pkg::MUL_BW'(in_elapsed_ms);
                mul_go_r <= 1'b1;
                state_r  <= ST_T_MUL;
              end
              default: state_r <= ST_DONE;
            endcase
          end
        end

        // aim: unit X-Z direction from (nx, nz) to the target
        ST_A_GO: begin
          mul_a_r  <= wpf_pkg::MUL_AW'(dx_m);
          mul_b_r  <= dx_m;
          mul_go_r <= 1'b1;
          state_r  <= ST_A_MX;
        end
        ST_A_MX: begin
          if (mul_done) begin
            sum_r    <= wpf_pkg::SQ_RW'(mul_p);
            mul_a_r  <= wpf_pkg::MUL_AW'(dz_m);
            mul_b_r  <= dz_m;
            mul_go_r <= 1'b1;
            state_r  <= ST_A_MZ;
          end
        end
        ST_A_MZ: begin
          if (mul_done) begin
            sq_rad_r <= sum_add;
            sq_go_r  <= 1'b1;
            state_r  <= ST_A_SQ;
          end
        end
        ST_A_SQ: begin
          if (sq_done) begin
            len_r <= sq_root;
            if (sq_root == '0) begin
              dir_x_r <= '0;
              dir_z_r <= '0;
              state_r <= ST_DONE;
            end else begin
              div_n_r  <= {dx_m, 16'h0000};
              div_d_r  <= sq_root;
              div_go_r <= 1'b1;
              state_r  <= ST_A_DX;
            end
          end
        end
        ST_A_DX: begin
          if (div_done) begin
            dir_x_r  <= signed_dir(div_q, dx[wpf_pkg::DIFF_W-1]);
            div_n_r  <= {dz_m, 16'h0000};
            div_d_r  <= len_r;
            div_go_r <= 1'b1;
            state_r  <= ST_A_DZ;
          end
        end
        ST_A_DZ: begin
          if (div_done) begin
            dir_z_r <= signed_dir(div_q, dz[wpf_pkg::DIFF_W-1]);
            state_r <= ST_DONE;
          end
        end

        // tick: step, distance, then snap or advance
        ST_T_MUL: begin
          if (mul_done) begin
            div_n_r  <= wpf_pkg::DIV_NW'(mul_p);
            div_d_r  <= wpf_pkg::MS_PER_S;
            div_go_r <= 1'b1;
            state_r  <= ST_T_DIV;
          end
        end
        ST_T_DIV: begin
          if (div_done) begin
            step_r   <= div_q[wpf_pkg::STEP_W-1:0];
            mul_a_r  <= wpf_pkg::MUL_AW'(dx_m);
            mul_b_r  <= dx_m;
            mul_go_r <= 1'b1;
            state_r  <= ST_T_SX;
          end
        end
        ST_T_SX: begin
          if (mul_done) begin
            sum_r    <= wpf_pkg::SQ_RW'(mul_p);
            mul_a_r  <= wpf_pkg::MUL_AW'(dy_m);
            mul_b_r  <= dy_m;
            mul_go_r <= 1'b1;
            state_r  <= ST_T_SY;
          end
        end
        ST_T_SY: begin
          if (mul_done) begin
            sum_r    <= sum_add;
            mul_a_r  <= wpf_pkg::MUL_AW'(dz_m);
            mul_b_r  <= dz_m;
            mul_go_r <= 1'b1;
            state_r  <= ST_T_SZ;
          end
        end
        ST_T_SZ: begin
          if (mul_done) begin
            sq_rad_r <= sum_add;
            sq_go_r  <= 1'b1;
            state_r  <= ST_T_SQ;
          end
        end
        ST_T_SQ: begin
          if (sq_done) begin
            if (wpf_pkg::STEP_W'(sq_root) < step_r) begin
              // snap onto the target
              nx_r <= tgt_r.x;
              ny_r <= tgt_r.y;
              nz_r <= tgt_r.z;
              if (count_r != '0) begin
                tgt_r   <= rd_r;
                head_r  <= head_inc;
                count_r <= count_r - 1'b1;
                state_r <= ST_A_GO;
              end else begin
                stop_r  <= 1'b1;
                state_r <= ST_DONE;
              end
            end else begin
              mul_a_r  <= step_r;
              mul_b_r  <= wpf_pkg::MUL_BW'(dxm_full[wpf_pkg::DIRM_W-1:0]);
              mul_go_r <= 1'b1;
              state_r  <= ST_T_AX;
            end
          end
        end
        ST_T_AX: begin
          if (mul_done) begin
            nx_r     <= sat_move(nx_r, mul_p, dir_x_r[wpf_pkg::DIR_W-1]);
            mul_a_r  <= step_r;
            mul_b_r  <= wpf_pkg::MUL_BW'(dzm_full[wpf_pkg::DIRM_W-1:0]);
            mul_go_r <= 1'b1;
            state_r  <= ST_T_AZ;
          end
        end
        ST_T_AZ: begin
          if (mul_done) begin
            nz_r    <= sat_move(nz_r, mul_p, dir_z_r[wpf_pkg::DIR_W-1]);
            state_r <= ST_DONE;
          end
        end

        // hand the result to the output register once it is free
        ST_DONE: begin
          if (res_load) begin
            out_x_r     <= nx_r;
            out_y_r     <= ny_r;
            out_z_r     <= nz_r;
            out_stop_r  <= stop_r;
            out_ovf_r   <= ovf_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  wpf_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_go_r),
    .a     (mul_a_r),
    .b     (mul_b_r),
    .done  (mul_done),
    .p     (mul_p)
  );

  wpf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go_r),
    .n     (div_n_r),
    .d     (div_d_r),
    .done  (div_done),
    .q     (div_q)
  );

  wpf_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_go_r),
    .rad   (sq_rad_r),
    .done  (sq_done),
    .root  (sq_root)
  );

  assign out_valid    = out_valid_r;
  assign out_new_x    = out_x_r;
  assign out_new_y    = out_y_r;
  assign out_new_z    = out_z_r;
  assign out_stopped  = out_stop_r;
  assign out_overflow = out_ovf_r;

endmodule

### design/wpf_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module wpf_mul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [wpf_pkg::MUL_AW-1:0] a,
  input  logic [wpf_pkg::MUL_BW-1:0] b,
  output logic                       done,
  output logic [wpf_pkg::MUL_PW-1:0] p
);

  localparam int CNT_W = $clog2(wpf_pkg::MUL_BW);

  logic                       busy_r;
  logic                       done_r;
  logic [CNT_W-1:0]           cnt_r;
  logic [wpf_pkg::MUL_PW-1:0] acc_r;
  logic [wpf_pkg::MUL_PW-1:0] ash_r;
  logic [wpf_pkg::MUL_BW-1:0] bsh_r;

  // add the shifted multiplicand for each set multiplier bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        acc_r  <= '0;
        ash_r  <= wpf_pkg::MUL_PW'(a);
        bsh_r  <= b;
      end else if (busy_r) begin
        if (bsh_r[0]) acc_r <= acc_r + ash_r;
        ash_r <= ash_r << 1;
        bsh_r <= bsh_r >> 1;
        if (cnt_r == CNT_W'(wpf_pkg::MUL_BW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

### design/wpf_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module wpf_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [wpf_pkg::DIV_NW-1:0] n,
  input  logic [wpf_pkg::DIV_DW-1:0] d,
  output logic                       done,
  output logic [wpf_pkg::DIV_NW-1:0] q
);

  localparam int CNT_W = $clog2(wpf_pkg::DIV_NW);

  logic                       busy_r;
  logic                       done_r;
  logic [CNT_W-1:0]           cnt_r;
  logic [wpf_pkg::DIV_NW-1:0] num_r;
  logic [wpf_pkg::DIV_DW-1:0] den_r;
  logic [wpf_pkg::DIV_DW-1:0] rem_r;
  logic [wpf_pkg::DIV_DW:0]   rem_t;
  logic                       fits;

  // trial subtract of the next partial remainder
  assign rem_t = {rem_r, num_r[wpf_pkg::DIV_NW-1]};
  assign fits  = rem_t >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        num_r  <= n;
        den_r  <= d;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= fits ? wpf_pkg::DIV_DW'(rem_t - {1'b0, den_r})
                      : wpf_pkg::DIV_DW'(rem_t);
        num_r <= {num_r[wpf_pkg::DIV_NW-2:0], fits};
        if (cnt_r == CNT_W'(wpf_pkg::DIV_NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign q    = num_r;

endmodule

### design/wpf_sqrt.sv
// Bit-serial integer square root, one root bit per cycle.
module wpf_sqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [wpf_pkg::SQ_RW-1:0] rad,
  output logic                      done,
  output logic [wpf_pkg::SQ_QW-1:0] root
);

  localparam int CNT_W = $clog2(wpf_pkg::SQ_QW);

  logic                      busy_r;
  logic                      done_r;
  logic [CNT_W-1:0]          cnt_r;
  logic [wpf_pkg::SQ_RW-1:0] rad_r;
  logic [wpf_pkg::SQ_MW-1:0] rem_r;
  logic [wpf_pkg::SQ_QW-1:0] root_r;
  logic [wpf_pkg::SQ_MW-1:0] rem_t;
  logic [wpf_pkg::SQ_MW-1:0] trial;
  logic                      fits;

  // bring down two radicand bits, try root*4+1
  assign rem_t = {rem_r[wpf_pkg::SQ_MW-3:0], rad_r[wpf_pkg::SQ_RW-1 -: 2]};
  assign trial = {1'b0, root_r, 2'b01};
  assign fits  = rem_t >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rad_r  <= rad;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        rem_r  <= fits ? rem_t - trial : rem_t;
        root_r <= {root_r[wpf_pkg::SQ_QW-2:0], fits};
        rad_r  <= rad_r << 2;
        if (cnt_r == CNT_W'(wpf_pkg::SQ_QW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

### design/wpf_checker.sv
// Port-level checker for the waypoint path follower, bound to the top level.
module wpf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_new_x,
  input logic [31:0] out_new_y,
  input logic [31:0] out_new_z,
  input logic        out_stopped,
  input logic        out_overflow
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_new_x) && $stable(out_new_y)
      && $stable(out_new_z) && $stable(out_stopped) && $stable(out_overflow))
    else $error("result changed while stalled");

  // a tick result and an append result never mix flags
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_stopped && out_overflow))
    else $error("stopped and overflow both set");

  // an accepted item keeps the input closed while it is worked on
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input open right after an accepted item");

  // reset leaves no result pending
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind waypoint_path_follower wpf_checker u_wpf_checker (.*);
